>>> hdl/ptc_pkg.sv
// Shared types and constants for the pressure and temperature compensation pipeline.
package ptc_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_TEMP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_A = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_B = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_C = 2'd3;

    localparam int FRONT_STAGES = 13;
    localparam int DIV_STAGES   = 64;
    localparam int BACK_STAGES  = 7;

    localparam logic [20:0] PN_BASE      = 21'd1048576;
    localparam logic [32:0] FINE_OFFSET  = 33'd128000;
    localparam logic [11:0] NUM_SCALE    = 12'd3125;
    localparam logic [63:0] BIAS_47      = 64'h0000_8000_0000_0000;
    localparam logic [31:0] ROUND_HALF   = 32'd128;

    typedef struct packed {
        logic        [15:0] t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic        [15:0] p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
    } t_cal;

    // values riding along with one item past the temperature stages
    typedef struct packed {
        logic [31:0] tc;
        logic [31:0] fine;
        logic        dz;
        logic        qneg;
    } t_side;

endpackage

>>> hdl/ptc_in_if.sv
// Input channel: raw temperature and pressure readings.
interface ptc_in_if;
    logic        valid;
    logic        ready;
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;

    modport source (output valid, output raw_temperature, output raw_pressure, input ready);
    modport sink   (input valid, input raw_temperature, input raw_pressure, output ready);
endinterface

>>> hdl/ptc_out_if.sv
// Output channel: compensated temperature and pressure.
interface ptc_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] temperature_centi;
    logic [31:0] fine_temperature;
    logic [31:0] pressure_q24_8;
    logic        pressure_invalid;

    modport source (output valid, output temperature_centi, output fine_temperature,
                    output pressure_q24_8, output pressure_invalid, input ready);
    modport sink   (input valid, input temperature_centi, input fine_temperature,
                    input pressure_q24_8, input pressure_invalid, output ready);
endinterface

>>> hdl/ptc_front.sv
// Temperature stages and pressure numerator/divisor stages ahead of the divider.
module ptc_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [19:0]          i_raw_t,
    input  logic [19:0]          i_raw_p,
    input  ptc_pkg::t_cal        i_cal,
    output logic                 o_valid,
    output logic [63:0]          o_nmag,
    output logic [30:0]          o_dmag,
    output ptc_pkg::t_side       o_side
);

    localparam int NS = ptc_pkg::FRONT_STAGES;

    logic [NS:1]  r_vld;
    logic [20:0]  r_pn   [1:9];
    logic [31:0]  r_fine [3:NS];
    logic [31:0]  r_tc   [4:NS];
    logic signed [48:0] r_v1p5 [5:7];
    logic signed [48:0] r_v1p2 [5:8];

    // stage 1
    logic signed [17:0] s1_d1;
    logic signed [16:0] s1_d2;
    logic signed [33:0] s1_m1, s1_sq;
    logic [31:0] r1_m1, r1_sq;
    assign s1_d1 = $signed({1'b0, i_raw_t[19:3]}) - $signed({1'b0, i_cal.t1, 1'b0});
    assign s1_d2 = $signed({1'b0, i_raw_t[19:4]}) - $signed({1'b0, i_cal.t1});
    assign s1_m1 = s1_d1 * $signed(i_cal.t2);
    assign s1_sq = s1_d2 * s1_d2;

    // stage 2
    logic signed [35:0] s2_m3;
    logic [20:0] r2_a1;
    logic [31:0] r2_m3;
    assign s2_m3 = $signed(r1_sq[31:12]) * $signed(i_cal.t3);

    // stage 4
    logic [31:0] s4_t5;
    logic signed [32:0] r4_v1;
    assign s4_t5 = r_fine[3] + {r_fine[3][29:0], 2'b00} + ptc_pkg::ROUND_HALF;

    // stage 5
    logic signed [16:0] s5_h;
    logic signed [33:0] s5_hh, s5_hl;
    logic signed [48:0] s5_v1p5, s5_v1p2;
    logic [31:0] s5_ll;
    logic signed [33:0] r5_hh, r5_hl;
    logic [31:0] r5_ll;
    assign s5_h    = r4_v1[32:16];
    assign s5_hh   = s5_h * s5_h;
    assign s5_hl   = s5_h * $signed({1'b0, r4_v1[15:0]});
    assign s5_ll   = r4_v1[15:0] * r4_v1[15:0];
    assign s5_v1p5 = r4_v1 * $signed(i_cal.p5);
    assign s5_v1p2 = r4_v1 * $signed(i_cal.p2);

    // stage 6
    logic [63:0] s6_hl_ext;
    logic [63:0] r6_sq;
    assign s6_hl_ext = {{30{r5_hl[33]}}, r5_hl};

    // stage 7
    logic signed [48:0] s7_lo6, s7_lo3;
    logic [47:0] s7_hi6, s7_hi3;
    logic signed [48:0] r7_lo6, r7_lo3;
    logic [31:0] r7_hi6, r7_hi3;
    assign s7_lo6 = $signed({1'b0, r6_sq[31:0]}) * $signed(i_cal.p6);
    assign s7_lo3 = $signed({1'b0, r6_sq[31:0]}) * $signed(i_cal.p3);
    // upper half only needs the low 32 bits, with the coefficient sign-extended
    assign s7_hi6 = r6_sq[63:32] * {{16{i_cal.p6[15]}}, i_cal.p6};
    assign s7_hi3 = r6_sq[63:32] * {{16{i_cal.p3[15]}}, i_cal.p3};

    // stage 8
    logic [63:0] s8_v1p5_ext;
    logic [63:0] r8_sq6, r8_sq3, r8_b5;
    assign s8_v1p5_ext = {{15{r_v1p5[7][48]}}, r_v1p5[7]};

    // stage 9
    logic [63:0] s9_v1p2_ext;
    logic [63:0] r9_v2, r9_u;
    assign s9_v1p2_ext = {{15{r_v1p2[8][48]}}, r_v1p2[8]};

    // stage 10
    logic [47:0] s10_ulo, s10_uhi;
    logic [63:0] r10_n0;
    logic [47:0] r10_ulo;
    logic [31:0] r10_uhi;
    assign s10_ulo = r9_u[31:0] * i_cal.p1;
    assign s10_uhi = r9_u[63:32] * i_cal.p1;

    // stage 11
    logic [63:0] s11_prod;
    logic [43:0] s11_nlo, s11_nhi;
    logic [30:0] r11_d;
    logic [43:0] r11_nlo;
    logic [31:0] r11_nhi;
    assign s11_prod = {16'b0, r10_ulo} + {r10_uhi, 32'b0};
    assign s11_nlo  = r10_n0[31:0] * ptc_pkg::NUM_SCALE;
    assign s11_nhi  = r10_n0[63:32] * ptc_pkg::NUM_SCALE;

    // stage 12, 13
    logic [63:0] r12_n;
    logic [30:0] r12_dmag, r13_dmag;
    logic        r12_dz, r12_dneg, r13_dz, r13_qneg;
    logic [63:0] r13_nmag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NS-1:1], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_m1    <= s1_m1[31:0];
            r1_sq    <= s1_sq[31:0];
            r_pn[1]  <= ptc_pkg::PN_BASE - {1'b0, i_raw_p};
            for (int k = 2; k <= 9; k++) r_pn[k] <= r_pn[k-1];

            r2_a1    <= r1_m1[31:11];
            r2_m3    <= s2_m3[31:0];

            r_fine[3] <= {{11{r2_a1[20]}}, r2_a1} + {{14{r2_m3[31]}}, r2_m3[31:14]};
            for (int k = 4; k <= NS; k++) r_fine[k] <= r_fine[k-1];

            r_tc[4]  <= {{8{s4_t5[31]}}, s4_t5[31:8]};
            for (int k = 5; k <= NS; k++) r_tc[k] <= r_tc[k-1];
            r4_v1    <= $signed({r_fine[3][31], r_fine[3]}) - $signed(ptc_pkg::FINE_OFFSET);

            r5_hh     <= s5_hh;
            r5_hl     <= s5_hl;
            r5_ll     <= s5_ll;
            r_v1p5[5] <= s5_v1p5;
            r_v1p2[5] <= s5_v1p2;
            for (int k = 6; k <= 7; k++) r_v1p5[k] <= r_v1p5[k-1];
            for (int k = 6; k <= 8; k++) r_v1p2[k] <= r_v1p2[k-1];

            r6_sq    <= {r5_hh[31:0], 32'b0} + {s6_hl_ext[46:0], 17'b0} + {32'b0, r5_ll};

            r7_lo6   <= s7_lo6;
            r7_lo3   <= s7_lo3;
            r7_hi6   <= s7_hi6[31:0];
            r7_hi3   <= s7_hi3[31:0];

            r8_sq6   <= {{15{r7_lo6[48]}}, r7_lo6} + {r7_hi6, 32'b0};
            r8_sq3   <= {{15{r7_lo3[48]}}, r7_lo3} + {r7_hi3, 32'b0};
            r8_b5    <= {s8_v1p5_ext[46:0], 17'b0}
                        + {{13{i_cal.p4[15]}}, i_cal.p4, 35'b0};

            r9_v2    <= r8_sq6 + r8_b5;
            r9_u     <= {{8{r8_sq3[63]}}, r8_sq3[63:8]} + {s9_v1p2_ext[51:0], 12'b0}
                        + ptc_pkg::BIAS_47;

            r10_n0   <= {12'b0, r_pn[9], 31'b0} - r9_v2;
            r10_ulo  <= s10_ulo;
            r10_uhi  <= s10_uhi[31:0];

            r11_d    <= s11_prod[63:33];
            r11_nlo  <= s11_nlo;
            r11_nhi  <= s11_nhi[31:0];

            r12_n    <= {20'b0, r11_nlo} + {r11_nhi, 32'b0};
            r12_dmag <= r11_d[30] ? (~r11_d + 31'd1) : r11_d;
            r12_dz   <= (r11_d == '0);
            r12_dneg <= r11_d[30];

            r13_nmag <= r12_n[63] ? (~r12_n + 64'd1) : r12_n;
            r13_qneg <= r12_n[63] ^ r12_dneg;
            r13_dmag <= r12_dmag;
            r13_dz   <= r12_dz;
        end
    end

    assign o_valid     = r_vld[NS];
    assign o_nmag      = r13_nmag;
    assign o_dmag      = r13_dmag;
    assign o_side.tc   = r_tc[NS];
    assign o_side.fine = r_fine[NS];
    assign o_side.dz   = r13_dz;
    assign o_side.qneg = r13_qneg;

endmodule

>>> hdl/ptc_div.sv
// Unsigned restoring divider, one quotient bit per pipeline stage.
module ptc_div (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [63:0]     i_nmag,
    input  logic [30:0]     i_dmag,
    input  ptc_pkg::t_side  i_side,
    output logic            o_valid,
    output logic [63:0]     o_quot,
    output ptc_pkg::t_side  o_side
);

    localparam int NS = ptc_pkg::DIV_STAGES;

    logic [NS-1:0]  r_vld;
    logic [30:0]    r_rem  [NS];
    logic [63:0]    r_word [NS];
    logic [30:0]    r_dm   [NS];
    ptc_pkg::t_side r_sd   [NS];

    logic [30:0] n_rem  [NS];
    logic [63:0] n_word [NS];

    always_comb begin
        logic [30:0] p_rem;
        logic [63:0] p_word;
        logic [30:0] p_dm;
        logic [31:0] t;
        logic [31:0] diff;
        logic        ge;
        for (int k = 0; k < NS; k++) begin
            if (k == 0) begin
                p_rem  = '0;
                p_word = i_nmag;
                p_dm   = i_dmag;
            end else begin
                p_rem  = r_rem[k-1];
                p_word = r_word[k-1];
                p_dm   = r_dm[k-1];
            end
            // shift in the next numerator bit, subtract when it fits
            t         = {p_rem, p_word[63]};
            diff      = t - {1'b0, p_dm};
            ge        = (t >= {1'b0, p_dm});
            n_rem[k]  = ge ? diff[30:0] : t[30:0];
            n_word[k] = {p_word[62:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NS; k++) begin
                r_rem[k]  <= n_rem[k];
                r_word[k] <= n_word[k];
            end
            r_dm[0] <= i_dmag;
            r_sd[0] <= i_side;
            for (int k = 1; k < NS; k++) begin
                r_dm[k] <= r_dm[k-1];
                r_sd[k] <= r_sd[k-1];
            end
        end
    end

    assign o_valid = r_vld[NS-1];
    assign o_quot  = r_word[NS-1];
    assign o_side  = r_sd[NS-1];

endmodule

>>> hdl/ptc_back.sv
// Pressure correction stages after the divider; the last stage is the output register.
module ptc_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [63:0]     i_quot,
    input  ptc_pkg::t_side  i_side,
    input  ptc_pkg::t_cal   i_cal,
    output logic            o_valid,
    output logic [31:0]     o_tc,
    output logic [31:0]     o_fine,
    output logic [31:0]     o_press,
    output logic            o_invalid
);

    localparam int NS = ptc_pkg::BACK_STAGES;

    logic [NS:1]    r_vld;
    ptc_pkg::t_side r_sd [1:NS-1];
    logic [63:0]    r_q  [1:5];
    logic [63:0]    r_pq8 [3:5];

    // stage 2
    logic [31:0] s2_xl, s2_xh;
    logic [63:0] s2_ll, s2_lh;
    logic signed [48:0] s2_q8lo;
    logic [47:0] s2_q8hi;
    logic [63:0] r2_ll;
    logic [31:0] r2_lh;
    logic signed [48:0] r2_q8lo;
    logic [31:0] r2_q8hi;
    assign s2_xl   = r_q[1][44:13];
    assign s2_xh   = {{13{r_q[1][63]}}, r_q[1][63:45]};
    assign s2_ll   = s2_xl * s2_xl;
    assign s2_lh   = s2_xl * s2_xh;
    assign s2_q8lo = $signed({1'b0, r_q[1][31:0]}) * $signed(i_cal.p8);
    assign s2_q8hi = r_q[1][63:32] * {{16{i_cal.p8[15]}}, i_cal.p8};

    // stage 3, 4, 5
    logic [63:0] r3_s2;
    logic signed [48:0] s4_lo9;
    logic [47:0] s4_hi9;
    logic signed [48:0] r4_lo9;
    logic [31:0] r4_hi9;
    logic [63:0] r5_pq9;
    assign s4_lo9 = $signed({1'b0, r3_s2[31:0]}) * $signed(i_cal.p9);
    assign s4_hi9 = r3_s2[63:32] * {{16{i_cal.p9[15]}}, i_cal.p9};

    // stage 6, 7
    logic [39:0] r6_sum;
    logic [31:0] s7_press;
    assign s7_press = r6_sum[39:8] + {{12{i_cal.p7[15]}}, i_cal.p7, 4'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NS-1:1], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sd[1] <= i_side;
            for (int k = 2; k <= NS-1; k++) r_sd[k] <= r_sd[k-1];

            // restore the quotient sign
            r_q[1] <= i_side.qneg ? (~i_quot + 64'd1) : i_quot;
            for (int k = 2; k <= 5; k++) r_q[k] <= r_q[k-1];

            r2_ll   <= s2_ll;
            r2_lh   <= s2_lh[31:0];
            r2_q8lo <= s2_q8lo;
            r2_q8hi <= s2_q8hi[31:0];

            r3_s2    <= r2_ll + {r2_lh[30:0], 33'b0};
            r_pq8[3] <= {{15{r2_q8lo[48]}}, r2_q8lo} + {r2_q8hi, 32'b0};
            for (int k = 4; k <= 5; k++) r_pq8[k] <= r_pq8[k-1];

            r4_lo9 <= s4_lo9;
            r4_hi9 <= s4_hi9[31:0];

            r5_pq9 <= {{15{r4_lo9[48]}}, r4_lo9} + {r4_hi9, 32'b0};

            r6_sum <= r_q[5][39:0] + {r5_pq9[63], r5_pq9[63:25]} + r_pq8[5][58:19];

            o_tc      <= r_sd[NS-1].tc;
            o_fine    <= r_sd[NS-1].fine;
            o_press   <= r_sd[NS-1].dz ? '0 : s7_press;
            o_invalid <= r_sd[NS-1].dz;
        end
    end

    assign o_valid = r_vld[NS];

endmodule

>>> hdl/pressure_temperature_compensation.sv
// Top level: calibration registers, pipeline control and the three pipeline sections.
//
//   channel   dir  handshake       payload
//   i_sample  in   valid / ready   raw_temperature[19:0], raw_pressure[19:0]
//   o_result  out  valid / ready   temperature_centi, fine_temperature,
//                                  pressure_q24_8, pressure_invalid
//   i_cfg_*   in   write enable    i_cfg_idx[1:0], i_cfg_data[47:0]
//
// One item enters per cycle while the pipeline is not stalled; it has 13 front, 64 divider and 7 back stages.
// The divider retires one quotient bit per stage, which sets the depth.
// The whole pipeline advances together; it moves whenever the output register
// is empty or being read, and bubbles inside it are held in place under a stall.
// Synchronous reset clears the valid bits and the calibration registers.
module pressure_temperature_compensation (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    ptc_in_if.sink                        i_sample,
    ptc_out_if.source                     o_result,
    input  logic                          i_cfg_we,
    input  logic [ptc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ptc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic [ptc_pkg::CFG_DATA_W-1:0] r_cal_t, r_cal_a, r_cal_b, r_cal_c;
    ptc_pkg::t_cal  cal;
    logic           en;

    logic           f_valid, d_valid;
    logic [63:0]    f_nmag, d_quot;
    logic [30:0]    f_dmag;
    ptc_pkg::t_side f_side, d_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_t <= '0;
            r_cal_a <= '0;
            r_cal_b <= '0;
            r_cal_c <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ptc_pkg::CFG_TEMP:    r_cal_t <= i_cfg_data;
                ptc_pkg::CFG_PRESS_A: r_cal_a <= i_cfg_data;
                ptc_pkg::CFG_PRESS_B: r_cal_b <= i_cfg_data;
                ptc_pkg::CFG_PRESS_C: r_cal_c <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign cal.t1 = r_cal_t[15:0];
    assign cal.t2 = r_cal_t[31:16];
    assign cal.t3 = r_cal_t[47:32];
    assign cal.p1 = r_cal_a[15:0];
    assign cal.p2 = r_cal_a[31:16];
    assign cal.p3 = r_cal_a[47:32];
    assign cal.p4 = r_cal_b[15:0];
    assign cal.p5 = r_cal_b[31:16];
    assign cal.p6 = r_cal_b[47:32];
    assign cal.p7 = r_cal_c[15:0];
    assign cal.p8 = r_cal_c[31:16];
    assign cal.p9 = r_cal_c[47:32];

    // advance when the output register is free or its beat is taken
    assign en             = !o_result.valid || o_result.ready;
    assign i_sample.ready = en;

    ptc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_sample.valid),
        .i_raw_t (i_sample.raw_temperature),
        .i_raw_p (i_sample.raw_pressure),
        .i_cal   (cal),
        .o_valid (f_valid),
        .o_nmag  (f_nmag),
        .o_dmag  (f_dmag),
        .o_side  (f_side)
    );

    ptc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_valid),
        .i_nmag  (f_nmag),
        .i_dmag  (f_dmag),
        .i_side  (f_side),
        .o_valid (d_valid),
        .o_quot  (d_quot),
        .o_side  (d_side)
    );

    ptc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (d_valid),
        .i_quot    (d_quot),
        .i_side    (d_side),
        .i_cal     (cal),
        .o_valid   (o_result.valid),
        .o_tc      (o_result.temperature_centi),
        .o_fine    (o_result.fine_temperature),
        .o_press   (o_result.pressure_q24_8),
        .o_invalid (o_result.pressure_invalid)
    );

    // temperature and fine temperature must leave in the same beat
    logic [31:0] chk_t5;
    logic [31:0] chk_tc;
    assign chk_t5 = o_result.fine_temperature + {o_result.fine_temperature[29:0], 2'b00}
                    + ptc_pkg::ROUND_HALF;
    assign chk_tc = {{8{chk_t5[31]}}, chk_t5[31:8]};

    a_tc_matches_fine: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> o_result.temperature_centi == chk_tc)
        else $error("temperature not aligned with fine temperature");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.pressure_invalid |-> o_result.pressure_q24_8 == '0)
        else $error("invalid pressure not forced to zero");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_result.valid)
        else $error("result valid right after reset");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && !o_result.ready |-> !i_sample.ready)
        else $error("input taken while pipeline stalled");

endmodule

>>> test/ptc_checker.sv
// Scoreboard for the compensation pipeline: predicts each result and compares it.
`timescale 1ns / 100ps
module ptc_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ptc_in_if          i_sample,
    ptc_out_if         o_result,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [47:0] i_cfg_data,
    output int         o_fail_count,
    output int         o_pending
);

    typedef struct packed {
        logic [31:0] tc;
        logic [31:0] fine;
        logic [31:0] press;
        logic        invalid;
    } t_comp;

    logic [47:0] cal_regs [4];
    t_comp       expected_q [$];

    function automatic logic signed [63:0] sx16(logic [47:0] r, int k);
        return 64'(signed'(r[16*k +: 16]));
    endfunction

    function automatic t_comp compensate(logic [19:0] adc_t, logic [19:0] adc_p);
        logic signed [31:0] t1, t2, t3, d1, a1, d2, a2, fine;
        logic signed [63:0] v1, v2, p, ps, w1, w2, mn, md, q;
        logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        t_comp r;
        t1 = {16'd0, cal_regs[ptc_pkg::CFG_TEMP][15:0]};
        t2 = 32'(sx16(cal_regs[ptc_pkg::CFG_TEMP], 1));
        t3 = 32'(sx16(cal_regs[ptc_pkg::CFG_TEMP], 2));
        d1 = 32'(adc_t >> 3) - (t1 <<< 1);
        a1 = (d1 * t2) >>> 11;
        d2 = 32'(adc_t >> 4) - t1;
        a2 = (((d2 * d2) >>> 12) * t3) >>> 14;
        fine = a1 + a2;
        r.fine = fine;
        r.tc = (fine * 32'sd5 + 32'sd128) >>> 8;
        p1 = {48'd0, cal_regs[ptc_pkg::CFG_PRESS_A][15:0]};
        p2 = sx16(cal_regs[ptc_pkg::CFG_PRESS_A], 1);
        p3 = sx16(cal_regs[ptc_pkg::CFG_PRESS_A], 2);
        p4 = sx16(cal_regs[ptc_pkg::CFG_PRESS_B], 0);
        p5 = sx16(cal_regs[ptc_pkg::CFG_PRESS_B], 1);
        p6 = sx16(cal_regs[ptc_pkg::CFG_PRESS_B], 2);
        p7 = sx16(cal_regs[ptc_pkg::CFG_PRESS_C], 0);
        p8 = sx16(cal_regs[ptc_pkg::CFG_PRESS_C], 1);
        p9 = sx16(cal_regs[ptc_pkg::CFG_PRESS_C], 2);
        v1 = 64'(fine) - 64'sd128000;
        v2 = v1 * v1 * p6 + ((v1 * p5) <<< 17) + (p4 <<< 35);
        v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
        v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
        r.press = '0;
        r.invalid = (v1 == 0);
        if (v1 != 0) begin
            p = 64'sd1048576 - 64'(adc_p);
            p = ((p <<< 31) - v2) * 64'sd3125;
            // truncating divide on magnitudes, wrap on overflow
            mn = p[63] ? -p : p;
            md = v1[63] ? -v1 : v1;
            q = 64'($unsigned(mn) / $unsigned(md));
            p = (p[63] != v1[63]) ? -q : q;
            ps = p >>> 13;
            w1 = (p9 * ps * ps) >>> 25;
            w2 = (p8 * p) >>> 19;
            p = ((p + w1 + w2) >>> 8) + (p7 <<< 4);
            r.press = p[31:0];
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        o_fail_count++;
    endtask

    assign o_pending = expected_q.size();

    initial o_fail_count = 0;

    always @(posedge i_clk) begin
        t_comp got, want;
        if (!i_rst_n) begin
            foreach (cal_regs[i]) cal_regs[i] <= '0;
        end else begin
            if (i_cfg_we) cal_regs[i_cfg_idx] <= i_cfg_data;
            if (i_sample.valid && i_sample.ready)
                expected_q.push_back(compensate(i_sample.raw_temperature,
                                                i_sample.raw_pressure));
            if (o_result.valid && o_result.ready) begin
                got = '{o_result.temperature_centi, o_result.fine_temperature,
                        o_result.pressure_q24_8, o_result.pressure_invalid};
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected beat", got.press, 32'd0);
                end else begin
                    want = expected_q.pop_front();
                    if (got.tc !== want.tc) report_mismatch("temperature", got.tc, want.tc);
                    if (got.fine !== want.fine) report_mismatch("fine", got.fine, want.fine);
                    if (got.press !== want.press)
                        report_mismatch("pressure", got.press, want.press);
                    if (got.invalid !== want.invalid)
                        report_mismatch("invalid", 32'(got.invalid), 32'(want.invalid));
                end
            end
        end
    end
endmodule

>>> test/tb_top.sv
// Stimulus and verdict for the pressure and temperature compensation pipeline.
`timescale 1ns / 100ps
module tb_top;

    localparam int LATENCY = ptc_pkg::FRONT_STAGES + ptc_pkg::DIV_STAGES
                             + ptc_pkg::BACK_STAGES;
    localparam int WATCHDOG_LIMIT = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [47:0] i_cfg_data;
    int          fail_count;
    int          pending;
    int          idle_cycles;
    int          stall_pct;
    bit          hold_off;
    bit          tail_wait;

    ptc_in_if  sample_ch ();
    ptc_out_if result_ch ();

    pressure_temperature_compensation dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_sample(sample_ch.sink),
        .o_result(result_ch.source), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    ptc_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_sample(sample_ch), .o_result(result_ch),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        sample_ch.valid = 0;
        sample_ch.raw_temperature = '0;
        sample_ch.raw_pressure = '0;
        result_ch.ready = 0;
        i_cfg_we = 0;
        i_cfg_idx = ptc_pkg::CFG_TEMP;
        i_cfg_data = '0;
        i_rst_n = 0;
        stall_pct = 13;
        hold_off = 0;
        tail_wait = 0;
    end

    // receiver: random stalls unless a hold-off is running
    always @(posedge i_clk) begin
        if (!i_rst_n || hold_off) begin
            result_ch.ready <= 1'b0;
        end else begin
            result_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (sample_ch.valid && sample_ch.ready) ||
            (result_ch.valid && result_ch.ready) || tail_wait)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired");
            $display("pressure_temperature_compensation test failed");
            $finish;
        end
    end

    // the caller drops the write enable after its last write
    task automatic write_reg(logic [1:0] idx, logic [47:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
    endtask

    // typical calibration with a random jitter on each word
    function automatic logic [47:0] jitter(logic [15:0] a, logic [15:0] b, logic [15:0] c);
        return {c + 16'($urandom_range(15)), b + 16'($urandom_range(15)),
                a + 16'($urandom_range(15))};
    endfunction

    task automatic load_cal(int mode);
        case (mode)
            0: begin
                write_reg(ptc_pkg::CFG_TEMP, jitter(16'd27504, 16'd26435, -16'sd1000));
                write_reg(ptc_pkg::CFG_PRESS_A, jitter(16'd36477, -16'sd10685, 16'd3024));
                write_reg(ptc_pkg::CFG_PRESS_B, jitter(16'd2855, 16'd140, -16'sd7));
                write_reg(ptc_pkg::CFG_PRESS_C, jitter(16'd15500, -16'sd14600, 16'd6000));
            end
            1: begin
                write_reg(ptc_pkg::CFG_TEMP, 48'h8000_7FFF_FFFF);
                write_reg(ptc_pkg::CFG_PRESS_A, 48'h7FFF_8000_FFFF);
                write_reg(ptc_pkg::CFG_PRESS_B, 48'h8000_7FFF_8000);
                write_reg(ptc_pkg::CFG_PRESS_C, 48'h7FFF_8000_7FFF);
            end
            2: begin
                write_reg(ptc_pkg::CFG_TEMP, 48'hFFFF_FFFF_FFFF);
                write_reg(ptc_pkg::CFG_PRESS_A, 48'h0000_0000_0000);
                write_reg(ptc_pkg::CFG_PRESS_B, 48'hFFFF_FFFF_FFFF);
                write_reg(ptc_pkg::CFG_PRESS_C, 48'hFFFF_FFFF_FFFF);
            end
            default: begin
                write_reg(ptc_pkg::CFG_TEMP, 48'({$urandom, $urandom}));
                write_reg(ptc_pkg::CFG_PRESS_A, 48'({$urandom, $urandom}));
                write_reg(ptc_pkg::CFG_PRESS_B, 48'({$urandom, $urandom}));
                write_reg(ptc_pkg::CFG_PRESS_C, 48'({$urandom, $urandom}));
            end
        endcase
        i_cfg_we <= 1'b0;
    endtask

    task automatic send(logic [19:0] t, logic [19:0] p, bit no_gaps);
        while (!no_gaps && $urandom_range(99) < 13) begin
            sample_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        sample_ch.valid <= 1'b1;
        sample_ch.raw_temperature <= t;
        sample_ch.raw_pressure <= p;
        do @(posedge i_clk); while (!sample_ch.ready);
    endtask

    task automatic drain();
        sample_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        tail_wait = 1;
        repeat (LATENCY + 8) @(posedge i_clk);
        tail_wait = 0;
    endtask

    task automatic random_phase(int count, int mode);
        logic [19:0] t, p;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(3))
                0: begin t = 20'($urandom); p = 20'($urandom); end
                default: begin
                    t = 20'd519888 + 20'($urandom_range(60000)) - 20'd30000;
                    p = 20'd415148 + 20'($urandom_range(200000)) - 20'd100000;
                end
            endcase
            send(t, p, mode == 1 && n > count / 2);
        end
        drain();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // zero calibration: divisor is zero, pressure invalid
        send(20'd0, 20'd0, 1);
        send(20'hFFFFF, 20'hFFFFF, 1);
        drain();
        load_cal(0);
        send(20'd519888, 20'd415148, 0);
        send(20'd0, 20'd0, 0);
        send(20'hFFFFF, 20'hFFFFF, 0);
        send(20'hAAAAA, 20'h55555, 0);
        send(20'h55555, 20'hAAAAA, 0);
        drain();
        load_cal(1);
        send(20'd0, 20'hFFFFF, 0);
        send(20'hFFFFF, 20'd0, 0);
        send(20'd519888, 20'd415148, 0);
        drain();
        load_cal(2);
        send(20'd12345, 20'd54321, 0);
        send(20'hFFFFF, 20'd0, 0);
        drain();

        load_cal(0);
        random_phase(140, 1);
        // hold the receiver off so the pipeline fills and stalls its input
        hold_off = 1;
        fork
            begin
                repeat (LATENCY * 3) @(posedge i_clk);
                hold_off = 0;
            end
            random_phase(120, 0);
        join
        load_cal(3);
        random_phase(60, 0);
        stall_pct = 0;
        load_cal(3);
        random_phase(60, 1);
        stall_pct = 13;
        load_cal(1);
        random_phase(50, 0);

        if (fail_count == 0)
            $display("pressure_temperature_compensation test passed");
        else
            $display("pressure_temperature_compensation test failed");
        $finish;
    end
endmodule

>>> filelist.f
hdl/ptc_pkg.sv
hdl/ptc_in_if.sv
hdl/ptc_out_if.sv
hdl/ptc_front.sv
hdl/ptc_div.sv
hdl/ptc_back.sv
hdl/pressure_temperature_compensation.sv
test/ptc_checker.sv
test/tb_top.sv
